// ----- design/saol_pkg.sv -----
package saol_pkg;

  localparam int unsigned SampleW     = 12;
  localparam int unsigned ChanOutW    = 3;
  localparam int unsigned ShiftW      = 3;
  localparam int unsigned ShiftChans  = 7;
  localparam int unsigned CfgW        = ShiftW * ShiftChans;
  localparam int unsigned CalSumW     = 16;

  localparam logic [CfgW-1:0] ShiftsReset = 21'd1009371;

  localparam int unsigned DefChannels   = 7;
  localparam int unsigned DefCalSamples = 16;

  typedef logic [SampleW-1:0]  sample_t;
  typedef logic [ChanOutW-1:0] chan_out_t;
  typedef logic [ShiftW-1:0]   shift_t;
  typedef logic [CfgW-1:0]     shifts_t;

endpackage

// ----- design/saol_in_if.sv -----
interface saol_in_if
  import saol_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// ----- design/saol_out_if.sv -----
interface saol_out_if
  import saol_pkg::*;
  ();
  logic      valid;
  logic      ready;
  chan_out_t channel;
  sample_t   filtered_value;
  sample_t   corrected_sample;
  logic      calibrating;
  chan_out_t next_channel;

  modport source (
    output valid, output channel, output filtered_value, output corrected_sample,
    output calibrating, output next_channel, input ready
  );
  modport sink (
    input valid, input channel, input filtered_value, input corrected_sample,
    input calibrating, input next_channel, output ready
  );
endinterface

// ----- design/saol_ema_step.sv -----
module saol_ema_step
  import saol_pkg::*;
(
  input  sample_t old_i,
  input  sample_t sample_i,
  input  shift_t  shift_i,
  output sample_t upd_o,
  output logic    changed_o
);

  logic    up;
  sample_t diff;
  sample_t step_raw;
  sample_t step;

  always_comb begin
    up        = sample_i > old_i;
    changed_o = sample_i != old_i;
    diff      = up ? (sample_i - old_i) : (old_i - sample_i);
    step_raw  = diff >> shift_i;
    // The value always moves by at least one count when it differs.
    step      = (step_raw == '0) ? sample_t'(1) : step_raw;
    if (!changed_o) begin
      upd_o = old_i;
    end else if (up) begin
      upd_o = old_i + step;
    end else begin
      upd_o = old_i - step;
    end
  end

endmodule

// ----- design/scanned_adc_offset_lowpass.sv -----
// A word accepted from adc_i passes through the input register into the result
// register on res_o. Throughput: one word per cycle while res_o is ready; the
// channel filter update is done in the single step between the two registers.
// Reset: the filters, the channel counter, the offset and the calibration
// sum clear, the shift register loads its default, and the next words after
// reset are taken as ground-reference samples for the offset.
module scanned_adc_offset_lowpass
  import saol_pkg::*;
#(
  parameter int unsigned CHANNELS    = DefChannels,
  parameter int unsigned CAL_SAMPLES = DefCalSamples
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  shifts_t           cfg_wdata_i,
  saol_in_if.sink           adc_i,
  saol_out_if.source        res_o
);

  localparam int unsigned ChW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CalRemW = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned CalShift = 20;
  localparam int unsigned ProdW   = CalSumW + CalShift + 1;
  localparam logic [CalShift:0] CalRecip =
    (CalShift + 1)'(((2 ** CalShift) + CAL_SAMPLES - 1) / CAL_SAMPLES);

  logic                 in_vld_q;
  sample_t              raw_q;
  logic                 out_vld_q;
  logic                 advance;

  shifts_t              shifts_q;
  sample_t              filt_q [CHANNELS];
  logic [ChW-1:0]       cur_ch_q;
  logic [ChW-1:0]       nxt_ch;
  logic [CalRemW-1:0]   cal_rem_q;
  logic [CalSumW-1:0]   cal_sum_q;
  logic [CalSumW-1:0]   cal_sum_d;
  sample_t              offset_q;
  sample_t              offset_d;
  logic [ProdW-1:0]     cal_prod;
  logic                 cal_active;

  sample_t              corrected;
  sample_t              old_val;
  sample_t              upd_val;
  logic                 changed;
  shift_t               shift_amt;
  logic [ChW+2:0]       cur_ext;
  logic [ChW+2:0]       nxt_ext;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign adc_i.ready = !in_vld_q || advance;
  assign cal_active  = cal_rem_q != '0;

  // Offset is the truncated mean, taken by a reciprocal multiply that is exact
  // over the whole range of the sum.
  always_comb begin
    cal_sum_d = cal_sum_q + CalSumW'(raw_q);
    cal_prod  = ProdW'(cal_sum_d) * ProdW'(CalRecip);
    offset_d  = cal_prod[CalShift +: SampleW];
  end

  always_comb begin
    corrected = (raw_q >= offset_q) ? (raw_q - offset_q) : '0;
    old_val   = filt_q[cur_ch_q];
    nxt_ch    = (cur_ch_q == ChW'(CHANNELS - 1)) ? '0 : (cur_ch_q + ChW'(1));
    cur_ext   = {3'b000, cur_ch_q};
    nxt_ext   = {3'b000, nxt_ch};
    shift_amt = '0;
    for (int i = 0; i < ShiftChans; i++) begin
      if (cur_ext == (ChW + 3)'(i)) begin
        shift_amt = shifts_q[ShiftW*i +: ShiftW];
      end
    end
  end

  saol_ema_step u_ema_step (
    .old_i     (old_val),
    .sample_i  (corrected),
    .shift_i   (shift_amt),
    .upd_o     (upd_val),
    .changed_o (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      shifts_q  <= ShiftsReset;
      cur_ch_q  <= '0;
      cal_rem_q <= CalRemW'(CAL_SAMPLES);
      cal_sum_q <= '0;
      offset_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        filt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        shifts_q <= cfg_wdata_i;
      end
      if (adc_i.ready) begin
        in_vld_q <= adc_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        if (cal_active) begin
          cal_rem_q <= cal_rem_q - CalRemW'(1);
          if (cal_rem_q == CalRemW'(1)) begin
            offset_q  <= offset_d;
            cal_sum_q <= '0;
          end else begin
            cal_sum_q <= cal_sum_d;
          end
        end else begin
          cur_ch_q <= nxt_ch;
          for (int i = 0; i < CHANNELS; i++) begin
            if (changed && (cur_ch_q == ChW'(i))) begin
              filt_q[i] <= upd_val;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adc_i.valid && adc_i.ready) begin
      raw_q <= adc_i.raw_sample;
    end
    if (advance) begin
      if (cal_active) begin
        res_o.channel          <= '0;
        res_o.filtered_value   <= '0;
        res_o.corrected_sample <= '0;
        res_o.calibrating      <= 1'b1;
        res_o.next_channel     <= '0;
      end else begin
        res_o.channel          <= cur_ext[ChanOutW-1:0];
        res_o.filtered_value   <= upd_val;
        res_o.corrected_sample <= corrected;
        res_o.calibrating      <= 1'b0;
        res_o.next_channel     <= nxt_ext[ChanOutW-1:0];
      end
    end
  end

  assign res_o.valid = out_vld_q;

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cur_ch_q} < (ChW + 1)'(CHANNELS))
    else $error("channel counter out of range");

  a_cal_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cal_rem_q} <= (CalRemW + 1)'(CAL_SAMPLES))
    else $error("calibration count out of range");

  a_filter_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.calibrating |-> cal_rem_q == '0)
    else $error("filtered word delivered during calibration");

  a_cal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.calibrating |->
      res_o.channel == '0 && res_o.filtered_value == '0 &&
      res_o.corrected_sample == '0 && res_o.next_channel == '0)
    else $error("calibration word carries nonzero fields");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(raw_q))
    else $error("pending input word lost");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import saol_pkg::*;

  localparam int unsigned NumChans = DefChannels;
  localparam int unsigned CalCount = DefCalSamples;
  localparam int unsigned IdlePct  = 22;

  typedef struct packed {
    chan_out_t channel;
    sample_t   filtered_value;
    sample_t   corrected_sample;
    logic      calibrating;
    chan_out_t next_channel;
  } lowpass_word_t;

  class lowpass_tracker;
    shifts_t             shifts;
    sample_t             filt[NumChans];
    int unsigned         chan;
    int unsigned         cal_left;
    logic [CalSumW-1:0]  cal_sum;
    sample_t             offset;
    lowpass_word_t       expected_words[$];
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      shifts = ShiftsReset;
      foreach (filt[i]) filt[i] = '0;
      chan = 0;
      cal_left = CalCount;
      cal_sum = '0;
      offset = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_sample(sample_t raw);
      lowpass_word_t w;
      int            oldv;
      int            newv;
      int            calc;
      shift_t        s;
      w = '0;
      if (cal_left > 0) begin
        cal_sum = cal_sum + raw;
        cal_left--;
        if (cal_left == 0) begin
          offset = sample_t'(cal_sum / CalCount);
          cal_sum = '0;
        end
        w.calibrating = 1'b1;
      end else begin
        newv = (raw >= offset) ? int'(raw) - int'(offset) : 0;
        oldv = int'(filt[chan]);
        s = shifts[ShiftW*chan +: ShiftW];
        if (newv != oldv) begin
          if (oldv < newv) begin
            calc = oldv + ((newv - oldv) >> s);
            if (calc == oldv) calc++;
          end else begin
            calc = oldv - ((oldv - newv) >> s);
            if (calc == oldv) calc--;
          end
          filt[chan] = sample_t'(calc);
        end
        w.channel = chan_out_t'(chan);
        w.filtered_value = filt[chan];
        w.corrected_sample = sample_t'(newv);
        chan = (chan + 1 == NumChans) ? 0 : chan + 1;
        w.next_channel = chan_out_t'(chan);
      end
      expected_words.push_back(w);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(lowpass_word_t got);
      lowpass_word_t want;
      checked++;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: channel %0d, filtered_value %0d",
               got.channel, got.filtered_value);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("filtered_value", want.filtered_value, got.filtered_value);
      compare_field("corrected_sample", want.corrected_sample, got.corrected_sample);
      compare_field("calibrating", want.calibrating, got.calibrating);
      compare_field("next_channel", want.next_channel, got.next_channel);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  shifts_t     cfg_wdata_i;
  int unsigned idle_pct = IdlePct;

  lowpass_tracker lowpass = new();

  saol_in_if  adc_if ();
  saol_out_if res_if ();

  scanned_adc_offset_lowpass i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adc_i       (adc_if),
    .res_o       (res_if)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_sample(input sample_t raw);
    while ($urandom_range(99) < idle_pct) begin
      adc_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    adc_if.valid <= 1'b1;
    adc_if.raw_sample <= raw;
    do @(posedge clk_i); while (!adc_if.ready);
    lowpass.note_sample(raw);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    adc_if.valid <= 1'b0;
    while (lowpass.expected_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_shifts(input shifts_t value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lowpass.shifts = value;
  endtask

  // Most words land on or near the filtered value or the offset, so that the
  // equal, single-step and clamp cases come up often.
  function automatic sample_t pick_sample();
    int unsigned roll;
    int          v;
    int          target;
    roll = $urandom_range(99);
    target = int'(lowpass.filt[lowpass.chan]) + int'(lowpass.offset);
    if (roll < 40) begin
      v = $urandom_range(4095);
    end else if (roll < 60) begin
      v = target;
    end else if (roll < 75) begin
      v = int'(lowpass.offset) + int'($urandom_range(6)) - 3;
    end else if (roll < 90) begin
      v = target + int'($urandom_range(40)) - 20;
    end else begin
      v = $urandom_range(1) ? 4095 : 0;
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    sample_t directed[$];
    adc_if.valid = 1'b0;
    adc_if.raw_sample = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample('0);
    send_sample(sample_t'(4095));
    repeat (CalCount - 2) send_sample(sample_t'($urandom_range(300)));

    directed = '{'0, lowpass.offset, sample_t'(4095), sample_t'(4095),
                 sample_t'(lowpass.offset - 1), sample_t'(1),
                 sample_t'(lowpass.offset + 1), sample_t'(4095), '0};
    foreach (directed[i]) send_sample(directed[i]);
    run_random(150);

    wait_idle();
    write_shifts('0);
    run_random(150);

    wait_idle();
    write_shifts('1);
    idle_pct = 0;
    run_random(150);

    wait_idle();
    idle_pct = IdlePct;
    write_shifts(shifts_t'($urandom));
    run_random(150);

    wait_idle();
    write_shifts(ShiftsReset);
    run_random(150);

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (lowpass.mismatches == 0 && lowpass.expected_words.size() == 0) begin
      $display("** scanned_adc_offset_lowpass: PASSED **");
    end else begin
      $display("** scanned_adc_offset_lowpass: FAILED **");
    end
    $finish;
  end

  // Once enough words have come back, the receiver holds off long enough
  // for the block to fill up and stall its input.
  initial begin
    int unsigned hold_left;
    bit          held;
    res_if.ready = 1'b0;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && lowpass.checked >= 250) begin
        held = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      lowpass.check_word('{channel:          res_if.channel,
                           filtered_value:   res_if.filtered_value,
                           corrected_sample: res_if.corrected_sample,
                           calibrating:      res_if.calibrating,
                           next_channel:     res_if.next_channel});
    end
  end

  initial begin
    #400us;
    $display("** scanned_adc_offset_lowpass: FAILED **");
    $finish;
  end

endmodule
